// ----- rtl/fixed_point_q24_8_alu_assert.svh -----
// Assertion macros used by the ALU top level.
`ifndef FIXED_POINT_Q24_8_ALU_ASSERT_SVH
`define FIXED_POINT_Q24_8_ALU_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define FPA_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define FPA_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/fpa_pkg.sv -----
`timescale 1ns / 1ps
package fpa_pkg;

	localparam int WORD_W = 32;
	localparam int FRAC_W = 8;
	localparam int NUM_W = WORD_W + FRAC_W;

	localparam logic [3:0] OP_ADD      = 4'd0;
	localparam logic [3:0] OP_SUB      = 4'd1;
	localparam logic [3:0] OP_MUL      = 4'd2;
	localparam logic [3:0] OP_DIV      = 4'd3;
	localparam logic [3:0] OP_GT       = 4'd4;
	localparam logic [3:0] OP_LT       = 4'd5;
	localparam logic [3:0] OP_GE       = 4'd6;
	localparam logic [3:0] OP_LE       = 4'd7;
	localparam logic [3:0] OP_EQ       = 4'd8;
	localparam logic [3:0] OP_NE       = 4'd9;
	localparam logic [3:0] OP_INC      = 4'd10;
	localparam logic [3:0] OP_DEC      = 4'd11;
	localparam logic [3:0] OP_MIN      = 4'd12;
	localparam logic [3:0] OP_MAX      = 4'd13;
	localparam logic [3:0] OP_TO_INT   = 4'd14;
	localparam logic [3:0] OP_FROM_INT = 4'd15;

	localparam logic [WORD_W-1:0] W_MAX = {1'b0, {(WORD_W-1){1'b1}}};
	localparam logic [WORD_W-1:0] W_MIN = {1'b1, {(WORD_W-1){1'b0}}};

	typedef struct packed {
		logic              valid;
		logic [3:0]        mode;
		logic [WORD_W-1:0] res;
		logic              cmp;
		logic              ovf;
		logic              dz;
		logic              neg;
	} item_t;

	typedef struct packed {
		logic [WORD_W-1:0] rem;
		logic [NUM_W-1:0]  quo;
		logic [NUM_W-1:0]  num;
		logic [WORD_W-1:0] den;
	} div_t;

	typedef struct packed {
		item_t item;
		div_t  dv;
	} cell_t;

	// Saturates a sum that grew by one bit: {overflow, word}.
	function automatic logic [WORD_W:0] sat_word(input logic [WORD_W:0] v);
		logic [WORD_W:0] r;
		if (v[WORD_W] != v[WORD_W-1]) begin
			r = {1'b1, (v[WORD_W] ? W_MIN : W_MAX)};
		end else begin
			r = {1'b0, v[WORD_W-1:0]};
		end
		return r;
	endfunction

	function automatic logic [WORD_W-1:0] mag_word(input logic [WORD_W-1:0] v);
		return v[WORD_W-1] ? (~v + 1'b1) : v;
	endfunction

endpackage

// ----- rtl/fpa_front.sv -----
`timescale 1ns / 1ps
module fpa_front import fpa_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic [3:0]               mode,
	input  logic signed [WORD_W-1:0] operand_a,
	input  logic signed [WORD_W-1:0] operand_b,
	output cell_t                    q
);

	logic vld_s1, vld_s2, vld_s3;
	cell_t pl_s1, pl_s2, pl_s3;
	logic signed [2*WORD_W-1:0] prod_s1;
	logic [2*WORD_W-1:0] pmag_s2;
	logic pneg_s2;

	cell_t c1;
	logic [WORD_W:0] a_x, b_x, sat_t;
	logic [FRAC_W:0] a_hi;

	always_comb begin
		a_x = {operand_a[WORD_W-1], operand_a};
		b_x = {operand_b[WORD_W-1], operand_b};
		a_hi = operand_a[WORD_W-1:WORD_W-FRAC_W-1];
		sat_t = '0;
		c1 = '0;
		c1.item.valid = in_valid;
		c1.item.mode = mode;
		c1.item.neg = operand_a[WORD_W-1] ^ operand_b[WORD_W-1];
		c1.dv.num = {mag_word(operand_a), {FRAC_W{1'b0}}};
		c1.dv.den = mag_word(operand_b);
		case (mode)
			OP_ADD: sat_t = sat_word(a_x + b_x);
			OP_SUB: sat_t = sat_word(a_x - b_x);
			OP_INC: sat_t = sat_word(a_x + 1'b1);
			OP_DEC: sat_t = sat_word(a_x - 1'b1);
			default: sat_t = '0;
		endcase
		case (mode)
			OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
				c1.item.res = sat_t[WORD_W-1:0];
				c1.item.ovf = sat_t[WORD_W];
			end
			OP_DIV: c1.item.dz = (operand_b == '0);
			OP_GT: c1.item.cmp = operand_a > operand_b;
			OP_LT: c1.item.cmp = operand_a < operand_b;
			OP_GE: c1.item.cmp = operand_a >= operand_b;
			OP_LE: c1.item.cmp = operand_a <= operand_b;
			OP_EQ: c1.item.cmp = operand_a == operand_b;
			OP_NE: c1.item.cmp = operand_a != operand_b;
			OP_MIN: c1.item.res = (operand_a < operand_b) ? operand_a : operand_b;
			OP_MAX: c1.item.res = (operand_a > operand_b) ? operand_a : operand_b;
			OP_TO_INT: c1.item.res = operand_a >>> FRAC_W;
			OP_FROM_INT: begin
				if (a_hi == '0 || a_hi == '1) begin
					c1.item.res = operand_a <<< FRAC_W;
				end else begin
					c1.item.res = operand_a[WORD_W-1] ? W_MIN : W_MAX;
					c1.item.ovf = 1'b1;
				end
			end
			default: c1.item.res = '0;
		endcase
	end

	// Multiply finishing: magnitude, then round half away from zero and clamp.
	logic [2*WORD_W-1:0] rnd;
	cell_t c3;
	always_comb begin
		rnd = (pmag_s2 + (64'd1 << (FRAC_W - 1))) >> FRAC_W;
		c3 = pl_s2;
		if (pl_s2.item.mode == OP_MUL) begin
			if (pneg_s2) begin
				if (rnd > {{WORD_W{1'b0}}, W_MIN}) begin
					c3.item.res = W_MIN;
					c3.item.ovf = 1'b1;
				end else begin
					c3.item.res = ~rnd[WORD_W-1:0] + 1'b1;
				end
			end else begin
				if (rnd > {{WORD_W{1'b0}}, W_MAX}) begin
					c3.item.res = W_MAX;
					c3.item.ovf = 1'b1;
				end else begin
					c3.item.res = rnd[WORD_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pl_s1 <= c1;
			prod_s1 <= operand_a * operand_b;
			pl_s2 <= pl_s1;
			pmag_s2 <= prod_s1[2*WORD_W-1] ? (~prod_s1 + 1'b1) : prod_s1;
			pneg_s2 <= prod_s1[2*WORD_W-1];
			pl_s3 <= c3;
		end
	end

	always_comb begin
		q = pl_s3;
		q.item.valid = vld_s3;
	end

endmodule

// ----- rtl/fpa_div_cell.sv -----
`timescale 1ns / 1ps
module fpa_div_cell import fpa_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  cell_t d,
	output cell_t q
);

	logic vld_q;
	cell_t pay_q;
	cell_t nxt;
	logic [WORD_W:0] trial, diff;
	logic ge;

	// One restoring step: bring down the next numerator bit, subtract if it fits.
	always_comb begin
		trial = {d.dv.rem, d.dv.num[NUM_W-1]};
		ge = trial >= {1'b0, d.dv.den};
		diff = trial - {1'b0, d.dv.den};
		nxt = d;
		nxt.dv.rem = ge ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
		nxt.dv.quo = {d.dv.quo[NUM_W-2:0], ge};
		nxt.dv.num = {d.dv.num[NUM_W-2:0], 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= d.item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_q <= nxt;
		end
	end

	always_comb begin
		q = pay_q;
		q.item.valid = vld_q;
	end

endmodule

// ----- rtl/fixed_point_q24_8_alu.sv -----
`timescale 1ns / 1ps
// Signed Q24.8 ALU with valid/ready channels. It accepts one item every
// cycle unless the output stalls and returns results in order through three
// front stages (operand prep and compares, a 32x32 multiply, multiply
// rounding), a row of 40 division cells that each settle one quotient bit,
// and the output register. Stalls on the output freeze the whole row.
module fixed_point_q24_8_alu import fpa_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [3:0]               mode,
	input  logic signed [WORD_W-1:0] operand_a,
	input  logic signed [WORD_W-1:0] operand_b,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [WORD_W-1:0] result,
	output logic                     compare_true,
	output logic                     overflow,
	output logic                     div_zero
);
`include "fixed_point_q24_8_alu_assert.svh"

	logic en;
	logic out_valid_q;
	logic [WORD_W-1:0] result_q;
	logic compare_q, overflow_q, div_zero_q;
	cell_t chain [0:NUM_W];

	assign en = !out_valid_q || out_ready;
	assign in_ready = en;

	fpa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.mode      (mode),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.q         (chain[0])
	);

	for (genvar i = 0; i < NUM_W; i++) begin : g_cell
		fpa_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.d      (chain[i]),
			.q      (chain[i+1])
		);
	end

	// Quotient rounding: add one when twice the remainder reaches the divisor.
	cell_t fin;
	logic up;
	logic [NUM_W:0] qr;
	logic [WORD_W-1:0] res_n;
	logic ovf_n;
	always_comb begin
		fin = chain[NUM_W];
		up = {fin.dv.rem, 1'b0} >= {1'b0, fin.dv.den};
		qr = {1'b0, fin.dv.quo} + {{NUM_W{1'b0}}, up};
		res_n = fin.item.res;
		ovf_n = fin.item.ovf;
		if (fin.item.mode == OP_DIV && !fin.item.dz) begin
			if (fin.item.neg) begin
				if (qr > {{(FRAC_W+1){1'b0}}, W_MIN}) begin
					res_n = W_MIN;
					ovf_n = 1'b1;
				end else begin
					res_n = ~qr[WORD_W-1:0] + 1'b1;
				end
			end else begin
				if (qr > {{(FRAC_W+1){1'b0}}, W_MAX}) begin
					res_n = W_MAX;
					ovf_n = 1'b1;
				end else begin
					res_n = qr[WORD_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= fin.item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result_q <= res_n;
			compare_q <= fin.item.cmp;
			overflow_q <= ovf_n;
			div_zero_q <= fin.item.dz;
		end
	end

	assign out_valid = out_valid_q;
	assign result = result_q;
	assign compare_true = compare_q;
	assign overflow = overflow_q;
	assign div_zero = div_zero_q;

	`FPA_ASSERT_IMP(a_dz_clean, out_valid && div_zero, result == '0 && !overflow, "div_zero with nonzero result or overflow")
	`FPA_ASSERT_IMP(a_cmp_zero, out_valid && compare_true, result == '0 && !overflow, "compare with nonzero result")
	`FPA_ASSERT_NXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(result) && $stable(overflow), "result changed under stall")
	`FPA_ASSERT_IMP(a_rem_bound, fin.item.valid && fin.dv.den != '0, fin.dv.rem < fin.dv.den, "division remainder not below divisor")

endmodule
